[hw/rtl/triangle_face_normal_top_defines.svh]
// ----------------------------------------------------------------------------
// Triangle face normal - assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH

// Same-cycle implication.
`define TFN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle face normal - package
// Widths, constants and sideband types shared by the normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NUM_COORDS       = 9;

    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W;
    localparam int MSB_W   = $clog2(MAG_W);

    localparam int NORM_W  = 31;           // a nonzero largest scaled magnitude sits in [2^30, 2^31)
    localparam int SQ_W    = 2 * NORM_W;
    localparam int LEN_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int QUOT_W  = NORMAL_FRAC_BITS + 2;
    localparam int DIV_W   = ROOT_W + QUOT_W;

    localparam int OUT_W   = 16;
    localparam logic [QUOT_W-1:0] OUT_MAX = QUOT_W'(32767);

    localparam int IN_TDATA_W  = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [NORM_W-1:0] m_x;
        logic [NORM_W-1:0] m_y;
        logic [NORM_W-1:0] m_z;
        logic [2:0]        neg;
        logic              deg;
        logic              last;
    } sqsb_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [2:0]        neg;
        logic              deg;
        logic              last;
    } dvsb_t;

endpackage

[hw/rtl/tfn_isqrt.sv]
// ----------------------------------------------------------------------------
// Triangle face normal - square root pipeline
// Floor square root of a 64-bit value, one root bit per register stage.
// ----------------------------------------------------------------------------
module tfn_isqrt
    import tfn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [LEN_W-1:0]  x,
    input  sqsb_t             in_sb,
    output logic              out_vld,
    output logic [ROOT_W-1:0] root,
    output sqsb_t             out_sb
);

    localparam int REM_W = LEN_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;
    sqsb_t             sb_reg   [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        logic              vld_in;
        sqsb_t             sb_in;

        if (j == 0) begin : g_first
            assign rem_in  = REM_W'(x);
            assign root_in = '0;
            assign vld_in  = in_vld;
            assign sb_in   = in_sb;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign vld_in  = vld_reg[j-1];
            assign sb_in   = sb_reg[j-1];
        end

        // (R + 2^K)^2 - R^2 = R * 2^(K+1) + 2^(2K)
        always_comb
        begin
            trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << K);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                sb_reg[j]   <= sb_in;
            end
        end
    end

    assign out_vld = vld_reg[ROOT_W-1];
    assign root    = root_reg[ROOT_W-1];
    assign out_sb  = sb_reg[ROOT_W-1];

endmodule

[hw/rtl/tfn_div.sv]
// ----------------------------------------------------------------------------
// Triangle face normal - divide pipeline
// Rounded quotient of each scaled component by the length, one bit per stage.
// ----------------------------------------------------------------------------
module tfn_div
    import tfn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [ROOT_W-1:0]       root,
    input  sqsb_t                   in_sb,
    output logic                    out_vld,
    output logic signed [OUT_W-1:0] normal_x,
    output logic signed [OUT_W-1:0] normal_y,
    output logic signed [OUT_W-1:0] normal_z,
    output logic                    degenerate,
    output logic                    last_out
);

    logic [DIV_W-1:0] num_reg [3];
    dvsb_t            pre_sb_reg;
    logic             pre_vld_reg;

    logic [DIV_W-1:0]  rem_reg [3][QUOT_W];
    logic [QUOT_W-1:0] q_reg   [3][QUOT_W];
    dvsb_t             sb_reg  [QUOT_W];
    logic [QUOT_W-1:0] vld_reg;

    logic signed [OUT_W-1:0] nrm_reg [3];
    logic signed [OUT_W-1:0] nrm_next [3];
    logic                    deg_reg;
    logic                    last_reg;
    logic                    out_vld_reg;

    logic [NORM_W-1:0] m_in [3];

    assign m_in[0] = in_sb.m_x;
    assign m_in[1] = in_sb.m_y;
    assign m_in[2] = in_sb.m_z;

    // Numerator with half the divisor added for round half up.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
                num_reg[l] <= (DIV_W'(m_in[l]) << NORMAL_FRAC_BITS) + DIV_W'(root >> 1);
            pre_sb_reg <= '{root: root, neg: in_sb.neg, deg: in_sb.deg, last: in_sb.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_vld_reg <= 1'b0;
        else if (en)
            pre_vld_reg <= in_vld;
    end

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        localparam int K = QUOT_W - 1 - j;
        dvsb_t sb_in;
        logic  vld_in;

        if (j == 0) begin : g_first
            assign sb_in  = pre_sb_reg;
            assign vld_in = pre_vld_reg;
        end else begin : g_rest
            assign sb_in  = sb_reg[j-1];
            assign vld_in = vld_reg[j-1];
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [DIV_W-1:0]  rem_in;
            logic [DIV_W-1:0]  dvs;
            logic [DIV_W-1:0]  rem_next;
            logic [QUOT_W-1:0] q_in;
            logic [QUOT_W-1:0] q_next;

            if (j == 0) begin : g_first
                assign rem_in = num_reg[l];
                assign q_in   = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[l][j-1];
                assign q_in   = q_reg[l][j-1];
            end

            always_comb
            begin
                dvs = DIV_W'(sb_in.root) << K;
                if (rem_in >= dvs)
                begin
                    rem_next = rem_in - dvs;
                    q_next   = q_in | (QUOT_W'(1) << K);
                end
                else
                begin
                    rem_next = rem_in;
                    q_next   = q_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[l][j] <= rem_next;
                    q_reg[l][j]   <= q_next;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sb_reg[j] <= sb_in;
        end
    end

    // Clamp, apply sign, force zero on a degenerate face.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [QUOT_W-1:0] qc;
            qc = (q_reg[l][QUOT_W-1] > OUT_MAX) ? OUT_MAX : q_reg[l][QUOT_W-1];
            if (sb_reg[QUOT_W-1].deg)
                nrm_next[l] = '0;
            else if (sb_reg[QUOT_W-1].neg[l])
                nrm_next[l] = -OUT_W'(qc);
            else
                nrm_next[l] = OUT_W'(qc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
                nrm_reg[l] <= nrm_next[l];
            deg_reg  <= sb_reg[QUOT_W-1].deg;
            last_reg <= sb_reg[QUOT_W-1].last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[QUOT_W-1];
    end

    assign out_vld    = out_vld_reg;
    assign normal_x   = nrm_reg[0];
    assign normal_y   = nrm_reg[1];
    assign normal_z   = nrm_reg[2];
    assign degenerate = deg_reg;
    assign last_out   = last_reg;

endmodule

[hw/rtl/triangle_face_normal_top.sv]
// ----------------------------------------------------------------------------
// Triangle face normal - top level
// Unit face normal of a triangle: edges, cross product, scale, length, divide.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser        tlast
//  s_axis    in   a.xyz, b.xyz, c.xyz (Q8.8)     -            last_face
//  m_axis    out  normal x, y, z (Q1.14)         degenerate   last_out
//
//  One triangle transfer per cycle while the output is not stalled; each result
//  passes through 9 front stages, 32 square root stages (one root bit each), one
//  numerator stage, 16 divide stages (one quotient bit each) and one output.
//  The whole pipeline advances while the output register is empty or taken;
//  a stalled output holds every stage, so nothing is lost or repeated.
//  Reset clears only the valid bits; no state passes between triangles.
`include "triangle_face_normal_top_defines.svh"

module triangle_face_normal_top
    import tfn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // normal_x, normal_y, normal_z from bit 0 up
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic en;

    // Advance when the output register is free or being taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [COORD_WIDTH-1:0] vert [NUM_COORDS];

    for (genvar i = 0; i < NUM_COORDS; i++) begin : g_unpack
        assign vert[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end

    // Valid bits of the front stages, one per stage.
    logic [8:0] vld_reg;
    logic [7:0] last_reg;

    // Stage 1: edges AB and AC, exact.
    logic signed [EDGE_W-1:0] ab_reg [3];
    logic signed [EDGE_W-1:0] ac_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= {vert[3+i][COORD_WIDTH-1], vert[3+i]}
                           - {vert[i][COORD_WIDTH-1], vert[i]};
                ac_reg[i] <= {vert[6+i][COORD_WIDTH-1], vert[6+i]}
                           - {vert[i][COORD_WIDTH-1], vert[i]};
            end
        end
    end

    // Stage 2: the six partial products of the cross product.
    logic signed [PROD_W-1:0] p_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= ab_reg[1] * ac_reg[2];
            p_reg[1] <= ab_reg[2] * ac_reg[1];
            p_reg[2] <= ab_reg[2] * ac_reg[0];
            p_reg[3] <= ab_reg[0] * ac_reg[2];
            p_reg[4] <= ab_reg[0] * ac_reg[1];
            p_reg[5] <= ab_reg[1] * ac_reg[0];
        end
    end

    // Stage 3: cross product components.
    logic signed [CROSS_W-1:0] n_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= p_reg[0] - p_reg[1];
            n_reg[1] <= p_reg[2] - p_reg[3];
            n_reg[2] <= p_reg[4] - p_reg[5];
        end
    end

    // Stage 4: magnitudes, signs, degenerate detect.
    logic [MAG_W-1:0] mag_reg [3];
    logic [2:0]       neg4_reg;
    logic             deg4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg4_reg[i] <= n_reg[i][CROSS_W-1];
                mag_reg[i]  <= n_reg[i][CROSS_W-1] ? MAG_W'(-n_reg[i]) : MAG_W'(n_reg[i]);
            end
            deg4_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        end
    end

    // Stage 5: largest magnitude.
    logic [MAG_W-1:0] mag5_reg [3];
    logic [MAG_W-1:0] big_reg;
    logic [MAG_W-1:0] big01;
    logic [2:0]       neg5_reg;
    logic             deg5_reg;

    assign big01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg  <= (big01 > mag_reg[2]) ? big01 : mag_reg[2];
            mag5_reg <= mag_reg;
            neg5_reg <= neg4_reg;
            deg5_reg <= deg4_reg;
        end
    end

    // Stage 6: leading one of the largest magnitude, turned into a shift.
    logic [MSB_W-1:0] msb;
    logic [MSB_W-1:0] sh_amt_reg;
    logic             sh_right_reg;
    logic [MAG_W-1:0] mag6_reg [3];
    logic [2:0]       neg6_reg;
    logic             deg6_reg;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < MAG_W; i++)
            if (big_reg[i])
                msb = MSB_W'(i);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Bring the leading one to bit 30.
            sh_right_reg <= (msb >= MSB_W'(NORM_W - 1));
            sh_amt_reg   <= (msb >= MSB_W'(NORM_W - 1)) ? msb - MSB_W'(NORM_W - 1)
                                                        : MSB_W'(NORM_W - 1) - msb;
            mag6_reg     <= mag5_reg;
            neg6_reg     <= neg5_reg;
            deg6_reg     <= deg5_reg;
        end
    end

    // Stage 7: scaled magnitudes, truncating on a right shift.
    logic [NORM_W-1:0] m7_reg [3];
    logic [2:0]        neg7_reg;
    logic              deg7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                m7_reg[i] <= sh_right_reg ? NORM_W'(mag6_reg[i] >> sh_amt_reg)
                                          : NORM_W'(mag6_reg[i]) << sh_amt_reg;
            neg7_reg <= neg6_reg;
            deg7_reg <= deg6_reg;
        end
    end

    // Stage 8: squares.
    logic [SQ_W-1:0]   sq_reg [3];
    logic [NORM_W-1:0] m8_reg [3];
    logic [2:0]        neg8_reg;
    logic              deg8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= m7_reg[i] * m7_reg[i];
            m8_reg   <= m7_reg;
            neg8_reg <= neg7_reg;
            deg8_reg <= deg7_reg;
        end
    end

    // Stage 9: squared length.
    logic [LEN_W-1:0] len2_reg;
    sqsb_t            sb9_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len2_reg <= LEN_W'(sq_reg[0]) + LEN_W'(sq_reg[1]) + LEN_W'(sq_reg[2]);
            sb9_reg  <= '{m_x: m8_reg[0], m_y: m8_reg[1], m_z: m8_reg[2],
                          neg: neg8_reg, deg: deg8_reg, last: last_reg[7]};
        end
    end

    // Valid and last travel alongside the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[7:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            last_reg <= {last_reg[6:0], s_axis_tlast};
    end

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    sqsb_t             sq_sb;

    tfn_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_reg[8]),
        .x       (len2_reg),
        .in_sb   (sb9_reg),
        .out_vld (sq_vld),
        .root    (sq_root),
        .out_sb  (sq_sb)
    );

    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;

    tfn_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (sq_vld),
        .root       (sq_root),
        .in_sb      (sq_sb),
        .out_vld    (m_axis_tvalid),
        .normal_x   (nx),
        .normal_y   (ny),
        .normal_z   (nz),
        .degenerate (m_axis_tuser),
        .last_out   (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'({nz, ny, nx});

    // Every component stays within one unit in Q1.14.
    logic in_unit;

    assign in_unit = (nx >= -16384) && (nx <= 16384) && (ny >= -16384) && (ny <= 16384)
                  && (nz >= -16384) && (nz <= 16384);

    `TFN_ASSERT_NOW(a_deg_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "degenerate face with nonzero normal")
    `TFN_ASSERT_NOW(a_live_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata != '0, "zero normal on a proper face")
    `TFN_ASSERT_NOW(a_unit_range, m_axis_tvalid, in_unit, "normal component beyond unit range")

endmodule
